// ----- rtl/core/msp_pkg.sv -----
// msp_pkg: shared types, codes and default sizes for the multi-stack pool.
// No dependencies; imported by msp_seq and multi_stack_shared_pool_unit.
`default_nettype none

package msp_pkg;

   localparam int MSP_NUM_STACKS = 4;
   localparam int MSP_POOL_SLOTS = 16;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic               func;
      logic [1:0]         stack_index;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_LOOK
   } seq_state_type;

   // sequencer to datapath
   typedef struct packed {
      logic accept;
      logic look;
   } seq_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/msp_ram.sv -----
// msp_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module msp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/msp_seq.sv -----
// msp_seq: two-step sequencer (look-up, then update) for one word at a time.
// Depends on msp_pkg.
`default_nettype none

module msp_seq import msp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output      logic   busy,
   output seq_ctrl_type ctrl
);

   seq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_LOOK;
            end
         end
         SEQ_LOOK: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      ctrl.accept = 1'b0;
      ctrl.look   = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            ctrl.accept = start;
         end
         SEQ_LOOK: begin
            busy      = 1'b1;
            ctrl.look = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/multi_stack_shared_pool_unit.sv -----
// multi_stack_shared_pool_unit: several LIFO stacks threaded through one slot pool.
// Depends on msp_pkg, msp_ram and msp_seq.
`default_nettype none

// Channel   Ports                       Direction  Handshake
// request   start, busy, req_data       in         taken when start & !busy
// response  rsp_valid, rsp_data         out        one-cycle strobe, no back-pressure
//
// For each word, the accept cycle issues the read of the chosen
// slot's link and data from the synchronous RAMs, the look cycle updates the
// heads and writes the RAMs, and the response appears in the following cycle,
// during which the next word may already be accepted.
// Reset (synchronous) empties all stacks and puts every slot on the free list.
// No clearing pass: a fill mark stands in for the initial link chain.
// The receiver cannot stall; every response is shown for exactly one cycle.

module multi_stack_shared_pool_unit import msp_pkg::*; #(
   parameter int NUM_STACKS = MSP_NUM_STACKS,
   parameter int POOL_SLOTS = MSP_POOL_SLOTS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output      logic    busy,
   output      logic    rsp_valid,
   output      rsp_type rsp_data
);

   localparam int AW = $clog2(POOL_SLOTS);           // slot address
   localparam int LW = $clog2(POOL_SLOTS + 1);       // link incl. null code
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

   seq_ctrl_type ctrl;

   // head pointers
   logic [LW-1:0] stack_head_ff [NUM_STACKS];
   logic [LW-1:0] free_head_ff;
   // fill mark: slots at or above it have never had their link written,
   // so their link is taken as its initial value (slot number plus one), not read from the RAM
   logic [LW-1:0] fill_ff;

   // word in flight
   logic               op_func_ff;
   logic [SW-1:0]      op_stk_ff;
   logic signed [31:0] op_value_ff;
   logic [AW-1:0]      op_slot_ff;
   logic               op_ok_ff;
   logic               op_fresh_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // accept-side decode
   logic          stk_in_range;
   logic [SW-1:0] stk_sel;
   logic [LW-1:0] top_link;
   logic [LW-1:0] pick_link;
   logic          pick_ok;

   // look-side
   logic [LW-1:0] link_q;
   logic [31:0]   data_q;
   logic [LW-1:0] link_rd;
   logic [LW-1:0] link_next;
   logic          do_write;
   logic          is_push;
   logic [LW-1:0] link_wr;

   msp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   assign stk_in_range = {30'd0, req_data.stack_index} < 32'(NUM_STACKS);
   assign stk_sel      = SW'(req_data.stack_index);
   assign top_link     = stk_in_range ? stack_head_ff[stk_sel] : NIL;
   assign pick_link    = (req_data.func == FUNC_POP) ? top_link : free_head_ff;
   assign pick_ok      = stk_in_range && (pick_link < NIL);

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_func_ff  <= req_data.func;
         op_stk_ff   <= stk_sel;
         op_value_ff <= req_data.push_value;
         op_slot_ff  <= AW'(pick_link);
         op_ok_ff    <= pick_ok;
         op_fresh_ff <= (pick_link >= fill_ff);
      end
   end

   // untouched links read as their reset value; anything out of range is null
   assign link_rd   = op_fresh_ff ? (LW'(op_slot_ff) + LW'(1)) : link_q;
   assign link_next = (link_rd < NIL) ? link_rd : NIL;
   assign is_push   = (op_func_ff == FUNC_PUSH);
   assign do_write  = ctrl.look && op_ok_ff;
   assign link_wr   = is_push ? stack_head_ff[op_stk_ff] : free_head_ff;

   msp_ram #(
      .WIDTH (LW),
      .DEPTH (POOL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (op_slot_ff),
      .wr_data (link_wr),
      .rd_en   (ctrl.accept),
      .rd_addr (AW'(pick_link)),
      .rd_data (link_q)
   );

   msp_ram #(
      .WIDTH (32),
      .DEPTH (POOL_SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (do_write && is_push),
      .wr_addr (op_slot_ff),
      .wr_data (op_value_ff),
      .rd_en   (ctrl.accept),
      .rd_addr (AW'(pick_link)),
      .rd_data (data_q)
   );

   // head and fill-mark updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            stack_head_ff[i] <= NIL;
         end
         free_head_ff <= '0;
         fill_ff      <= '0;
      end else if (do_write) begin
         if (is_push) begin
            // slot leaves the free list and becomes the new top
            free_head_ff             <= link_next;
            stack_head_ff[op_stk_ff] <= LW'(op_slot_ff);
            if (LW'(op_slot_ff) == fill_ff) begin
               fill_ff <= fill_ff + LW'(1);
            end
         end else begin
            // top slot goes back to the head of the free list
            stack_head_ff[op_stk_ff] <= link_next;
            free_head_ff             <= LW'(op_slot_ff);
         end
      end
   end

   always_comb begin
      rsp_data_in.pop_value = '0;
      if (op_ok_ff) begin
         rsp_data_in.status = ST_OK;
         if (!is_push) begin
            rsp_data_in.pop_value = data_q;
         end
      end else if (is_push) begin
         rsp_data_in.status = ST_FULL;
      end else begin
         rsp_data_in.status = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.look;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.look) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
